@@ rtl/core/tks_pkg.sv @@
package tks_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_INV_TEMP = 2'd0,
        REG_TOP_K    = 2'd1,
        REG_TOP_P    = 2'd2,
        REG_SEED     = 2'd3
    } tks_reg_t;

    // Back-end sequencer states
    typedef enum logic [4:0] {
        BK_IDLE,
        BK_WEIGHT,
        BK_RUN,
        BK_RD,
        BK_MG,
        BK_PROD_LO,
        BK_PROD_HI,
        BK_SCAN_RD,
        BK_SCAN_ACC,
        BK_XS,
        BK_U0,
        BK_U1,
        BK_U2,
        BK_R0,
        BK_R1,
        BK_PICK_RD,
        BK_PICK_ACC,
        BK_OUT
    } tks_state_t;

    localparam logic [63:0]        XS_MULT     = 64'h2545F4914F6CDD1D;
    localparam logic [15:0]        LOG2E_Q15   = 16'd47274;
    localparam logic [63:0]        LN2_Q32     = 64'd2977044472;
    localparam int                 Y_FRAC_BITS = 35;
    localparam logic [16:0]        TOP_P_ONE   = 17'd65536;
    localparam logic signed [15:0] LOGIT_MIN   = 16'sh8000;
    localparam logic [15:0]        BEST_RESET  = 16'h8000;

    // Job handed from front to back at the end of a vocabulary
    typedef struct packed {
        logic               greedy;
        logic [15:0]        inv_temp;
        logic [16:0]        top_k;
        logic [16:0]        top_p;
        logic signed [15:0] best_value;
    } tks_job_t;

    // Generator seed load
    typedef struct packed {
        logic        load;
        logic [63:0] value;
    } tks_seed_t;

    // 2^(-f/DEPTH) in Q0.32 from the 16-term series of e^-x, x in Q0.32
    function automatic logic [31:0] exp_series(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        term = ((term * x) >> 32) / 64'd1;  sum = sum - term;
        term = ((term * x) >> 32) / 64'd2;  sum = sum + term;
        term = ((term * x) >> 32) / 64'd3;  sum = sum - term;
        term = ((term * x) >> 32) / 64'd4;  sum = sum + term;
        term = ((term * x) >> 32) / 64'd5;  sum = sum - term;
        term = ((term * x) >> 32) / 64'd6;  sum = sum + term;
        term = ((term * x) >> 32) / 64'd7;  sum = sum - term;
        term = ((term * x) >> 32) / 64'd8;  sum = sum + term;
        term = ((term * x) >> 32) / 64'd9;  sum = sum - term;
        term = ((term * x) >> 32) / 64'd10; sum = sum + term;
        term = ((term * x) >> 32) / 64'd11; sum = sum - term;
        term = ((term * x) >> 32) / 64'd12; sum = sum + term;
        term = ((term * x) >> 32) / 64'd13; sum = sum - term;
        term = ((term * x) >> 32) / 64'd14; sum = sum + term;
        term = ((term * x) >> 32) / 64'd15; sum = sum - term;
        term = ((term * x) >> 32) / 64'd16; sum = sum + term;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

endpackage

@@ rtl/core/tks_front.sv @@
module tks_front
    import tks_pkg::*;
#(
    parameter int VOCAB_MAX = 65536
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic signed [15:0]                logit,
    input  logic                              last,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              q_valid,
    input  logic                              logit_busy,
    output logic                              lw_en,
    output logic [$clog2(VOCAB_MAX)-1:0]      lw_addr,
    output logic [15:0]                       lw_data,
    output logic                              push,
    output tks_job_t                          push_job,
    output logic [$clog2(VOCAB_MAX+1)-1:0]    push_n,
    output logic [$clog2(VOCAB_MAX)-1:0]      push_best,
    output tks_seed_t                         seed
);

    localparam int IDX_W = $clog2(VOCAB_MAX);
    localparam int CNT_W = $clog2(VOCAB_MAX + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [15:0] best_val_reg;
    logic signed [15:0] best_val_next;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [IDX_W-1:0]   best_idx_next;
    logic [15:0]        inv_temp_reg;
    logic [16:0]        top_k_reg;
    logic [16:0]        top_p_reg;
    logic               accept;
    logic               stored;
    logic               better;

    // Hold input while the queue has a job or the back end reads logits
    assign item_ready = !q_valid && !logit_busy;
    assign accept     = item_valid && item_ready;
    assign stored     = count_reg < CNT_W'(VOCAB_MAX);
    assign better     = stored && (logit > best_val_reg);

    assign lw_en   = accept && stored;
    assign lw_addr = count_reg[IDX_W-1:0];
    assign lw_data = logit;

    // Track running maximum and item count
    always_comb
    begin
        count_next    = stored ? count_reg + CNT_W'(1) : count_reg;
        best_val_next = better ? logit : best_val_reg;
        best_idx_next = better ? count_reg[IDX_W-1:0] : best_idx_reg;
    end

    // Build the job on the last transfer
    assign push                = accept && last;
    assign push_n              = count_next;
    assign push_best           = best_idx_next;
    assign push_job.greedy     = (inv_temp_reg == 16'd0) || (top_k_reg == 17'd1);
    assign push_job.inv_temp   = inv_temp_reg;
    assign push_job.top_k      = top_k_reg;
    assign push_job.top_p      = top_p_reg;
    assign push_job.best_value = best_val_next;

    assign seed.load  = cfg_write && (cfg_index == REG_SEED);
    assign seed.value = cfg_data;

    // Advance count and maximum, clear after the last transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            best_val_reg <= LOGIT_MIN;
            best_idx_reg <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg    <= '0;
                best_val_reg <= LOGIT_MIN;
                best_idx_reg <= '0;
            end
            else
            begin
                count_reg    <= count_next;
                best_val_reg <= best_val_next;
                best_idx_reg <= best_idx_next;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_temp_reg <= '0;
            top_k_reg    <= '0;
            top_p_reg    <= TOP_P_ONE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INV_TEMP: inv_temp_reg <= cfg_data[15:0];
                REG_TOP_K:    top_k_reg    <= cfg_data[16:0];
                REG_TOP_P:    top_p_reg    <= cfg_data[16:0];
                default:      ;
            endcase
        end
    end

endmodule

@@ rtl/core/tks_queue.sv @@
module tks_queue #(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full     = fill_reg == 2'd2;
    assign valid    = fill_reg != 2'd0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
        end
    end

endmodule

@@ rtl/core/tks_back.sv @@
module tks_back
    import tks_pkg::*;
#(
    parameter int VOCAB_MAX       = 65536,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              lw_en,
    input  logic [$clog2(VOCAB_MAX)-1:0]      lw_addr,
    input  logic [15:0]                       lw_data,
    input  tks_seed_t                         seed,
    input  logic                              q_valid,
    input  tks_job_t                          q_job,
    input  logic [$clog2(VOCAB_MAX+1)-1:0]    q_n,
    input  logic [$clog2(VOCAB_MAX)-1:0]      q_best,
    output logic                              q_pop,
    output logic                              logit_busy,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [15:0]                       token_id
);

    localparam int IDX_W = $clog2(VOCAB_MAX);
    localparam int CNT_W = $clog2(VOCAB_MAX + 1);
    localparam int SW    = CNT_W + 3;
    localparam int REC_W = 32 + IDX_W;
    localparam int TOT_W = 32 + IDX_W;
    localparam int PW    = TOT_W + 17;
    localparam int TIX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int DW    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int FP_W  = Y_FRAC_BITS + DW;

    // Exponent table
    logic [31:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_exp
        localparam logic [63:0] XArg = (LN2_Q32 * 64'(g)) / 64'(EXP_TABLE_DEPTH);
        assign exp_rom[g] = exp_series(XArg);
    end

    // Memories: logits, and records {weight, index} in two banks
    logic [15:0]      logit_mem [VOCAB_MAX];
    logic [REC_W-1:0] rec_mem [2**(IDX_W+1)];

    tks_state_t         state_reg;
    tks_state_t         state_next;
    logic [63:0]        rng_reg;
    logic               result_valid_reg;
    logic [IDX_W-1:0]   pick_reg;

    logic [CNT_W-1:0]   n_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic signed [15:0] best_val_reg;
    logic [15:0]        inv_reg;
    logic [CNT_W-1:0]   kk_reg;
    logic [16:0]        thr_reg;
    logic               greedy_reg;

    logic [CNT_W-1:0]   wi_reg;
    logic [15:0]        logit_rd_reg;
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]   idx2_reg, idx3_reg, idx4_reg, idx1_reg;
    logic [31:0]        p1_reg;
    logic [47:0]        y_reg;
    logic [12:0]        whole_reg;
    logic [TIX_W-1:0]   tix_reg;
    logic [TOT_W-1:0]   total_reg;

    logic [SW-1:0]      w_reg, lo_reg, mid_reg, hi_reg, p_reg, q_reg, o_reg;
    logic               src_reg;
    logic [REC_W-1:0]   rd_a_reg, rd_b_reg;

    logic [PW-1:0]      prod_reg;
    logic [CNT_W-1:0]   i_reg;
    logic [CNT_W-1:0]   keep_reg;
    logic [TOT_W-1:0]   kept_reg;
    logic [TOT_W-1:0]   acc_reg;
    logic [IDX_W-1:0]   first_reg;
    logic [31:0]        u_reg;
    logic [TOT_W-1:0]   r_reg;

    logic               rec_we;
    logic [IDX_W:0]     rec_waddr;
    logic [REC_W-1:0]   rec_wdata;
    logic [IDX_W:0]     ra, rb;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    logic [15:0]        diff;
    logic [FP_W-1:0]    fprod;
    logic [31:0]        wgt;
    logic               weight_done;
    logic [SW-1:0]      n_ext, lo_w, lo_2w, mid_c, hi_c;
    logic               take_q;
    logic [SW-1:0]      p_adv, q_adv;
    logic [31:0]        a_prob, b_prob, rd_prob;
    logic [IDX_W-1:0]   a_idx, b_idx, rd_idx;
    logic [TOT_W-1:0]   kept_n, acc_n;
    logic               p_hit;
    logic [63:0]        xs1, xs2, xs3;
    logic               out_free;

    assign logit_busy   = state_reg == BK_WEIGHT;
    assign result_valid = result_valid_reg;
    assign out_free     = !result_valid_reg || result_ready;
    assign mul_p        = mul_a * mul_b;

    // Weight pipeline arithmetic
    assign diff  = 16'(17'(best_val_reg) - 17'($signed(logit_rd_reg)));
    assign fprod = FP_W'(y_reg[Y_FRAC_BITS-1:0]) * FP_W'(EXP_TABLE_DEPTH);
    assign wgt   = (whole_reg >= 13'd32) ? 32'd0 : (exp_rom[tix_reg] >> whole_reg[4:0]);
    assign weight_done = (wi_reg == n_reg) && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    // Merge run bounds and head compare
    assign n_ext  = SW'(n_reg);
    assign lo_w   = lo_reg + w_reg;
    assign lo_2w  = lo_reg + (w_reg << 1);
    assign mid_c  = (lo_w < n_ext) ? lo_w : n_ext;
    assign hi_c   = (lo_2w < n_ext) ? lo_2w : n_ext;
    assign a_prob = rd_a_reg[REC_W-1:IDX_W];
    assign a_idx  = rd_a_reg[IDX_W-1:0];
    assign b_prob = rd_b_reg[REC_W-1:IDX_W];
    assign b_idx  = rd_b_reg[IDX_W-1:0];
    assign take_q = (q_reg < hi_reg) && ((p_reg >= mid_reg) || (b_prob > a_prob)
                    || ((b_prob == a_prob) && (b_idx < a_idx)));
    assign p_adv  = take_q ? p_reg : p_reg + SW'(1);
    assign q_adv  = take_q ? q_reg + SW'(1) : q_reg;

    // Scan and pick accumulation
    assign rd_prob = a_prob;
    assign rd_idx  = a_idx;
    assign kept_n  = kept_reg + TOT_W'(rd_prob);
    assign acc_n   = acc_reg + TOT_W'(rd_prob);
    assign p_hit   = (PW'(kept_n) << 16) >= prod_reg;

    // Generator step
    assign xs1 = rng_reg ^ (rng_reg >> 12);
    assign xs2 = xs1 ^ (xs1 << 25);
    assign xs3 = xs2 ^ (xs2 >> 27);

    // Next state, memory ports and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rec_we     = 1'b0;
        rec_waddr  = '0;
        rec_wdata  = '0;
        ra         = '0;
        rb         = '0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = q_job.greedy ? BK_OUT : BK_WEIGHT;
                end
            end
            BK_WEIGHT:
            begin
                rec_we    = v4_reg;
                rec_waddr = {1'b0, idx4_reg};
                rec_wdata = {wgt, idx4_reg};
                if (weight_done)
                begin
                    state_next = (n_reg <= CNT_W'(1)) ? BK_PROD_LO : BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (lo_reg >= n_ext)
                begin
                    state_next = ((w_reg << 1) >= n_ext) ? BK_PROD_LO : BK_RUN;
                end
                else
                begin
                    state_next = BK_RD;
                end
            end
            BK_RD:
            begin
                ra         = {src_reg, p_reg[IDX_W-1:0]};
                rb         = {src_reg, q_reg[IDX_W-1:0]};
                state_next = BK_MG;
            end
            BK_MG:
            begin
                rec_we    = 1'b1;
                rec_waddr = {!src_reg, o_reg[IDX_W-1:0]};
                rec_wdata = take_q ? rd_b_reg : rd_a_reg;
                state_next = ((p_adv >= mid_reg) && (q_adv >= hi_reg)) ? BK_RUN : BK_RD;
            end
            BK_PROD_LO:
            begin
                mul_a      = total_reg[31:0];
                mul_b      = 32'(thr_reg);
                state_next = BK_PROD_HI;
            end
            BK_PROD_HI:
            begin
                mul_a      = 32'(total_reg[TOT_W-1:32]);
                mul_b      = 32'(thr_reg);
                state_next = BK_SCAN_RD;
            end
            BK_SCAN_RD:
            begin
                ra         = {src_reg, i_reg[IDX_W-1:0]};
                state_next = (i_reg >= kk_reg) ? BK_XS : BK_SCAN_ACC;
            end
            BK_SCAN_ACC:
            begin
                state_next = p_hit ? BK_XS : BK_SCAN_RD;
            end
            BK_XS:
            begin
                state_next = BK_U0;
            end
            BK_U0:
            begin
                mul_a      = rng_reg[31:0];
                mul_b      = XS_MULT[31:0];
                state_next = BK_U1;
            end
            BK_U1:
            begin
                mul_a      = rng_reg[31:0];
                mul_b      = XS_MULT[63:32];
                state_next = BK_U2;
            end
            BK_U2:
            begin
                mul_a      = rng_reg[63:32];
                mul_b      = XS_MULT[31:0];
                state_next = BK_R0;
            end
            BK_R0:
            begin
                mul_a      = u_reg;
                mul_b      = kept_reg[31:0];
                state_next = BK_R1;
            end
            BK_R1:
            begin
                mul_a      = u_reg;
                mul_b      = 32'(kept_reg[TOT_W-1:32]);
                state_next = BK_PICK_RD;
            end
            BK_PICK_RD:
            begin
                ra         = {src_reg, i_reg[IDX_W-1:0]};
                state_next = (i_reg >= keep_reg) ? BK_OUT : BK_PICK_ACC;
            end
            BK_PICK_ACC:
            begin
                state_next = (r_reg <= acc_n) ? BK_OUT : BK_PICK_RD;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers and generator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
            rng_reg          <= 64'd1;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == BK_WEIGHT) && (wi_reg < n_reg);
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (seed.load)
            begin
                rng_reg <= seed.value;
            end
            else if (state_reg == BK_XS)
            begin
                rng_reg <= xs3;
            end
            if ((state_reg == BK_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Memory access
    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            logit_mem[lw_addr] <= lw_data;
        end
        logit_rd_reg <= logit_mem[wi_reg[IDX_W-1:0]];
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rd_a_reg <= rec_mem[ra];
        rd_b_reg <= rec_mem[rb];
    end

    // Weight pipeline stages
    always_ff @(posedge clk)
    begin
        idx1_reg  <= wi_reg[IDX_W-1:0];
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        idx4_reg  <= idx3_reg;
        p1_reg    <= 32'(diff) * 32'(inv_reg);
        y_reg     <= 48'(p1_reg) * 48'(LOG2E_Q15);
        whole_reg <= y_reg[47:Y_FRAC_BITS];
        tix_reg   <= fprod[Y_FRAC_BITS +: TIX_W];
    end

    // Sequencer datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                n_reg        <= q_n;
                best_idx_reg <= q_best;
                best_val_reg <= q_job.best_value;
                inv_reg      <= q_job.inv_temp;
                greedy_reg   <= q_job.greedy;
                kk_reg       <= ((q_job.top_k == 17'd0) || (32'(q_job.top_k) >= 32'(q_n)))
                                ? q_n : CNT_W'(q_job.top_k);
                thr_reg      <= ((q_job.top_p == 17'd0) || (q_job.top_p > TOP_P_ONE))
                                ? TOP_P_ONE : q_job.top_p;
                pick_reg     <= q_best;
                wi_reg       <= '0;
                total_reg    <= '0;
            end
            BK_WEIGHT:
            begin
                if (wi_reg < n_reg)
                begin
                    wi_reg <= wi_reg + CNT_W'(1);
                end
                if (v4_reg)
                begin
                    total_reg <= total_reg + TOT_W'(wgt);
                end
                w_reg   <= SW'(1);
                lo_reg  <= '0;
                src_reg <= 1'b0;
            end
            BK_RUN:
            begin
                if (lo_reg >= n_ext)
                begin
                    src_reg <= !src_reg;
                    w_reg   <= w_reg << 1;
                    lo_reg  <= '0;
                end
                else
                begin
                    mid_reg <= mid_c;
                    hi_reg  <= hi_c;
                    p_reg   <= lo_reg;
                    q_reg   <= mid_c;
                    o_reg   <= lo_reg;
                end
            end
            BK_MG:
            begin
                o_reg <= o_reg + SW'(1);
                p_reg <= p_adv;
                q_reg <= q_adv;
                if ((p_adv >= mid_reg) && (q_adv >= hi_reg))
                begin
                    lo_reg <= lo_2w;
                end
            end
            BK_PROD_LO:
            begin
                prod_reg <= PW'(mul_p);
            end
            BK_PROD_HI:
            begin
                prod_reg <= prod_reg + (PW'(mul_p) << 32);
                i_reg    <= '0;
                kept_reg <= '0;
            end
            BK_SCAN_RD:
            begin
                if (i_reg >= kk_reg)
                begin
                    keep_reg <= kk_reg;
                end
            end
            BK_SCAN_ACC:
            begin
                kept_reg <= kept_n;
                if (i_reg == '0)
                begin
                    first_reg <= rd_idx;
                end
                if (p_hit)
                begin
                    keep_reg <= i_reg + CNT_W'(1);
                end
                else
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            BK_U0:
            begin
                u_reg <= mul_p[63:32];
            end
            BK_U1, BK_U2:
            begin
                u_reg <= u_reg + mul_p[31:0];
            end
            BK_R0:
            begin
                r_reg <= TOT_W'(mul_p[63:32]);
            end
            BK_R1:
            begin
                r_reg   <= r_reg + TOT_W'(mul_p);
                i_reg   <= '0;
                acc_reg <= '0;
            end
            BK_PICK_RD:
            begin
                if (i_reg >= keep_reg)
                begin
                    pick_reg <= first_reg;
                end
            end
            BK_PICK_ACC:
            begin
                acc_reg <= acc_n;
                if (r_reg <= acc_n)
                begin
                    pick_reg <= rd_idx;
                end
                else
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    token_id <= 16'(greedy_reg ? best_idx_reg : pick_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/core/token_sampler_topk_topp.sv @@
// Loading: one logit transfer per cycle while the job queue is empty and no weight pass
// reads logits. Greedy result: the job skips weighting and goes straight to output.
// Sampling result: a weight pass, ceil(log2 n) merge passes, a top-p scan over the kept
// entries, then the draw and the pick.
// The next vocabulary loads once the weight pass has read the logit memory.
// Reset (async, active low) clears control, restores register defaults and seeds 1.
module token_sampler_topk_topp
    import tks_pkg::*;
#(
    parameter int VOCAB_MAX       = 65536,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] logit,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [15:0]        token_id,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int IDX_W = $clog2(VOCAB_MAX);
    localparam int CNT_W = $clog2(VOCAB_MAX + 1);
    localparam int QW    = $bits(tks_job_t) + CNT_W + IDX_W;

    logic               q_valid;
    logic               q_full;
    logic               q_pop;
    logic               push;
    logic               logit_busy;
    logic               lw_en;
    logic [IDX_W-1:0]   lw_addr;
    logic [15:0]        lw_data;
    tks_job_t           push_job;
    logic [CNT_W-1:0]   push_n;
    logic [IDX_W-1:0]   push_best;
    tks_seed_t          seed;
    logic [QW-1:0]      q_data;
    tks_job_t           q_job;
    logic [CNT_W-1:0]   q_n;
    logic [IDX_W-1:0]   q_best;

    // Accept and classify logits
    tks_front #(
        .VOCAB_MAX (VOCAB_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .logit      (logit),
        .last       (last),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .logit_busy (logit_busy),
        .lw_en      (lw_en),
        .lw_addr    (lw_addr),
        .lw_data    (lw_data),
        .push       (push),
        .push_job   (push_job),
        .push_n     (push_n),
        .push_best  (push_best),
        .seed       (seed)
    );

    // Job queue between front and back
    tks_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_job, push_n, push_best}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    assign {q_job, q_n, q_best} = q_data;

    // Weight, sort, truncate and draw
    tks_back #(
        .VOCAB_MAX       (VOCAB_MAX),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .lw_en        (lw_en),
        .lw_addr      (lw_addr),
        .lw_data      (lw_data),
        .seed         (seed),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_n          (q_n),
        .q_best       (q_best),
        .q_pop        (q_pop),
        .logit_busy   (logit_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .token_id     (token_id)
    );

`ifndef SYNTHESIS
    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("job pushed into a full queue");

    a_no_load_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        logit_busy |-> !item_ready)
        else $error("logit taken while weight pass reads the store");

    a_pop_after_push : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> q_valid)
        else $error("pushed job not visible in queue");

    a_token_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(token_id) < VOCAB_MAX))
        else $error("token id beyond vocabulary");
`endif

endmodule
